[src/pacu_pkg.sv]
`timescale 1ns / 1ps

package pacu_pkg;

    localparam int TIME_W      = 40;
    localparam int COUNT_W     = 16;
    localparam int SCALE_W     = 17;
    localparam int PERIOD_W    = COUNT_W + SCALE_W;
    localparam int DIV_STEPS   = TIME_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W  = 3;

    localparam logic [TIME_W-1:0] LATE_LIMIT = TIME_W'(60 * 5);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    localparam logic [SCALE_W-1:0] SECS_PER_SEC  = SCALE_W'(1);
    localparam logic [SCALE_W-1:0] SECS_PER_MIN  = SCALE_W'(60);
    localparam logic [SCALE_W-1:0] SECS_PER_HOUR = SCALE_W'(60 * 60);
    localparam logic [SCALE_W-1:0] SECS_PER_DAY  = SCALE_W'(60 * 60 * 24);

    typedef enum logic [1:0] {
        UNIT_SEC  = 2'd0,
        UNIT_MIN  = 2'd1,
        UNIT_HOUR = 2'd2,
        UNIT_DAY  = 2'd3
    } pacu_unit_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ARMED  = 3'd0,
        CFG_REPEAT = 3'd1,
        CFG_COUNT  = 3'd2,
        CFG_UNIT   = 3'd3,
        CFG_IGNORE = 3'd4,
        CFG_START  = 3'd5
    } pacu_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } pacu_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pacu_div_stat_t;

    function automatic logic [SCALE_W-1:0] period_scale(input logic [1:0] unit);
        logic [SCALE_W-1:0] s;
        unique case (pacu_unit_t'(unit))
            UNIT_SEC:  s = SECS_PER_SEC;
            UNIT_MIN:  s = SECS_PER_MIN;
            UNIT_HOUR: s = SECS_PER_HOUR;
            UNIT_DAY:  s = SECS_PER_DAY;
            default:   s = SECS_PER_SEC;
        endcase
        return s;
    endfunction

endpackage

[src/pacu_rem_div.sv]
`timescale 1ns / 1ps

// restoring remainder, one dividend bit per cycle
module pacu_rem_div
    import pacu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [TIME_W-1:0]   dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output pacu_div_stat_t      stat,
    output logic [PERIOD_W-1:0] remainder
);

    logic [TIME_W-1:0]     dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W+1:0]   diff;

    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
            // borrow clear means trial >= divisor
            rem_next = diff[PERIOD_W+1] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

[src/periodic_alarm_catch_up_top.sv]
`timescale 1ns / 1ps

// channel   | ports                      | direction | payload
// ----------+----------------------------+-----------+----------------------------------
// input     | s_tvalid s_tready s_tdata  | in        | now_seconds
// result    | m_tvalid m_tready m_tdata  | out       | fire, late_suppressed,
//           |                            |           | zero_period, next_due
// config    | cfg_we cfg_addr cfg_wdata  | in        | register write, no read-back
//
// an item that needs a catch-up goes from accept to result through the period
// multiply, a compare that starts the remainder, the bit-serial remainder of
// lateness by period, a step to see it finish, an update and the load of the
// output register; the next transaction is taken in the cycle after that load
// items that need no catch-up skip the remainder and the update; a new item is
// taken only once the last one has left the sequencer; the remainder loop sets the rate
// aresetn is synchronous and active low; due time resets to zero
// a result waiting in the output register does not block acceptance of the next
// transaction; the sequencer only stalls on a full output register at its end
module periodic_alarm_catch_up_top
    import pacu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // [39:0] now_seconds

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [0] fire, [1] late_suppressed,
                                             // [2] zero_period, [42:3] next_due,
                                             // [47:43] zero

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TIME_W-1:0]     cfg_wdata
);

    // configuration registers
    logic                armed_reg;
    logic                repeat_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [1:0]          unit_reg;
    logic                ignore_reg;

    // alarm state
    logic [TIME_W-1:0]   due_reg, due_next;

    // per-item working registers
    logic [TIME_W-1:0]   now_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                fire_reg, supp_reg, zero_reg;

    // output register
    logic                m_valid_reg;

    pacu_state_t         state_reg, state_next;

    // sequencer controls
    logic                take_item;
    logic                do_mul;
    logic                do_eval;
    logic                div_start;
    logic                do_upd;
    logic                emit;

    // evaluation of the captured time against due time
    logic                is_due;
    logic                need_repeat;
    logic                period_zero;
    logic                too_late;
    logic [TIME_W-1:0]   late;

    pacu_div_stat_t      div_stat;
    logic [PERIOD_W-1:0] div_rem;
    logic [TIME_W:0]     next_sum;

    assign late        = now_reg - due_reg;
    assign is_due      = armed_reg && (due_reg <= now_reg);
    assign too_late    = late > LATE_LIMIT;
    assign need_repeat = is_due && repeat_reg;
    assign period_zero = (period_reg == '0);

    // due + (late/period + 1)*period == now - late%period + period
    assign next_sum = {1'b0, now_reg} - {{(TIME_W + 1 - PERIOD_W){1'b0}}, div_rem}
                    + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_EVAL;
            ST_EVAL: state_next = (need_repeat && !period_zero) ? ST_DIV : ST_DONE;
            ST_DIV:  if (div_stat.done) state_next = ST_UPD;
            ST_UPD:  state_next = ST_DONE;
            ST_DONE: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        take_item = 1'b0;
        do_mul    = 1'b0;
        do_eval   = 1'b0;
        div_start = 1'b0;
        do_upd    = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: take_item = 1'b1;
            ST_MUL:  do_mul = 1'b1;
            ST_EVAL: begin
                do_eval   = 1'b1;
                div_start = need_repeat && !period_zero;
            end
            ST_DIV:  ;
            ST_UPD:  do_upd = 1'b1;
            ST_DONE: emit = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign s_tready = take_item;

    // due time: start_time writes reload it, catch-up advances it with saturation
    always_comb begin
        due_next = due_reg;
        if (cfg_we && (cfg_addr == CFG_START)) begin
            due_next = cfg_wdata;
        end else if (do_upd) begin
            due_next = next_sum[TIME_W] ? TIME_MAX : next_sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            armed_reg   <= 1'b0;
            repeat_reg  <= 1'b1;
            count_reg   <= COUNT_W'(1);
            unit_reg    <= UNIT_DAY;
            ignore_reg  <= 1'b0;
            due_reg     <= '0;
        end else begin
            state_reg <= state_next;
            due_reg   <= due_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_ARMED:  armed_reg  <= cfg_wdata[0];
                    CFG_REPEAT: repeat_reg <= cfg_wdata[0];
                    CFG_COUNT:  count_reg  <= cfg_wdata[COUNT_W-1:0];
                    CFG_UNIT:   unit_reg   <= cfg_wdata[1:0];
                    CFG_IGNORE: ignore_reg <= cfg_wdata[0];
                    default:    ;   // start time handled with due time
                endcase
            end
        end
    end

    // payload registers
    logic [47:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (take_item && s_tvalid) begin
            now_reg <= s_tdata;
        end
        if (do_mul) begin
            period_reg <= {{SCALE_W{1'b0}}, count_reg}
                        * {{COUNT_W{1'b0}}, period_scale(unit_reg)};
        end
        if (do_eval) begin
            fire_reg <= is_due && !(ignore_reg && too_late);
            supp_reg <= is_due && ignore_reg && too_late;
            zero_reg <= need_repeat && period_zero;
        end
        if (emit) begin
            m_data_reg <= {5'b0, due_reg, zero_reg, supp_reg, fire_reg};
        end
    end

    pacu_rem_div u_rem_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (late),
        .divisor   (period_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // a result never both fires and reports suppression
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("fire and late_suppressed both set");

    // zero period is only reported on a due alarm
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[0] || m_tdata[1]))
        else $error("zero_period without due alarm");

    // one item at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // remainder unit completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide phase");

    // the divider is never restarted while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");
`endif

endmodule
